// ===== hdl/u8s_pkg.sv =====
package u8s_pkg;

	// Replacement character and byte-class masks
	localparam logic [7:0] SUB_CHAR   = 8'h3F;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_CODE  = 8'h80;

	// Most results one byte can release, and depth of the result queue
	localparam int MAX_RUN    = 4;
	localparam int FIFO_DEPTH = 8;

	// One input transfer
	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} raw_t;

	// One result transfer
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_last;
	} res_t;

	// 1 for ASCII, 2..4 for a lead, 0 for a continuation or invalid byte
	function automatic logic [2:0] seq_length(input logic [7:0] c);
		logic [2:0] len;
		if (c[7] == 1'b0)
			len = 3'd1;
		else if (c[7:5] == 3'b110)
			len = 3'd2;
		else if (c[7:4] == 4'b1110)
			len = 3'd3;
		else if (c[7:3] == 5'b11110)
			len = 3'd4;
		else
			len = 3'd0;
		return len;
	endfunction

endpackage

// ===== hdl/utf8_sanitizer_stream_top.sv =====
// Channel  | Direction | Payload         | Handshake
// raw      | in        | u8s_pkg::raw_t  | raw_valid / raw_stall
// clean    | out       | u8s_pkg::res_t  | clean_valid / clean_stall
//
// A byte is registered on entry and classified the next cycle; each byte in
// gives 0 to 4 bytes out; one byte per cycle is sustained while the result queue has room.
// A classified byte releases 0 to 4 results into an 8-entry result queue; the
// stage waits while the queue could not take four more, which only happens
// when the output side stalls.
// An accepted byte passes the input register and then the result queue before its results can leave.
// Reset clears the held sequence and the queue; the held bytes need no reset.
module utf8_sanitizer_stream_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           raw_valid,
	output logic           raw_stall,
	input  u8s_pkg::raw_t  raw_item,
	output logic           clean_valid,
	input  logic           clean_stall,
	output u8s_pkg::res_t  clean_item
);

	localparam int PTR_W = $clog2(u8s_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(u8s_pkg::FIFO_DEPTH + 1);
	localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(u8s_pkg::FIFO_DEPTH - u8s_pkg::MAX_RUN);

	// Input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Held sequence
	logic [7:0]  pend_q [3];
	logic [1:0]  pcnt_q;
	logic [2:0]  need_q;

	// Result queue
	u8s_pkg::res_t      fifo_q [u8s_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	logic        proc;
	logic        pop;
	logic        accept;
	logic        cont;
	logic        complete;
	logic        broken;
	logic        fresh_emit;
	logic [2:0]  len;
	logic [2:0]  pc_ext;
	logic [2:0]  n_res;
	logic [7:0]  fresh_out;
	u8s_pkg::res_t res [u8s_pkg::MAX_RUN];

	assign proc      = valid_s1 && (count_q <= ROOM_LIMIT);
	assign pop       = clean_valid && !clean_stall;
	assign raw_stall = valid_s1 && !proc;
	assign accept    = raw_valid && !raw_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= raw_item.in_byte;
			last_s1 <= raw_item.is_last;
		end
	end

	// Classify the byte against the held sequence
	always_comb begin
		logic [2:0] kk;
		kk         = '0;
		pc_ext     = {1'b0, pcnt_q};
		cont       = (byte_s1 & u8s_pkg::CONT_MASK) == u8s_pkg::CONT_CODE;
		len        = u8s_pkg::seq_length(byte_s1);
		complete   = (pcnt_q != 2'd0) && cont && ((pc_ext + 3'd1) == need_q);
		broken     = (pcnt_q != 2'd0) && cont && !complete && (last_s1 || pcnt_q == 2'd3);
		fresh_emit = (len == 3'd1) || (len == 3'd0) || last_s1;
		fresh_out  = (len == 3'd1) ? byte_s1 : u8s_pkg::SUB_CHAR;

		if ((pcnt_q != 2'd0) && cont)
			n_res = (complete || broken) ? pc_ext + 3'd1 : 3'd0;
		else
			n_res = pc_ext + {2'b00, fresh_emit};

		for (int k = 0; k < u8s_pkg::MAX_RUN; k++) begin
			kk = 3'(k);
			if (kk < pc_ext)
				res[k].out_byte = (complete && k < 3) ? pend_q[k[1:0]] : u8s_pkg::SUB_CHAR;
			else if (complete)
				res[k].out_byte = byte_s1;
			else if (broken)
				res[k].out_byte = u8s_pkg::SUB_CHAR;
			else
				res[k].out_byte = fresh_out;
			res[k].run_last    = (kk + 3'd1) == n_res;
			res[k].string_last = ((kk + 3'd1) == n_res) && last_s1;
		end
	end

	// Held sequence update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= 2'd0;
			need_q <= 3'd0;
		end else if (proc) begin
			if (last_s1 || complete || broken) begin
				pcnt_q <= 2'd0;
				need_q <= 3'd0;
			end else if ((pcnt_q != 2'd0) && cont) begin
				pcnt_q <= pcnt_q + 2'd1;
			end else if (len >= 3'd2) begin
				pcnt_q <= 2'd1;
				need_q <= len;
			end else begin
				pcnt_q <= 2'd0;
				need_q <= 3'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc && !last_s1) begin
			if ((pcnt_q != 2'd0) && cont) begin
				if (!complete && !broken)
					pend_q[pcnt_q] <= byte_s1;
			end else if (len >= 3'd2) begin
				pend_q[0] <= byte_s1;
			end
		end
	end

	// Result queue: up to four writes, one read per cycle while the output side does not stall
	always_ff @(posedge clk) begin
		if (proc) begin
			for (int k = 0; k < u8s_pkg::MAX_RUN; k++) begin
				if (3'(k) < n_res)
					fifo_q[wr_ptr_q + PTR_W'(k)] <= res[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (proc)
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + (proc ? CNT_W'(n_res) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	assign clean_valid = count_q != '0;
	assign clean_item  = fifo_q[rd_ptr_q];

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(u8s_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_need_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(pcnt_q != 2'd0) |-> ((need_q > pc_ext) && (need_q <= 3'd4)))
		else $error("held count out of step with sequence length");

	a_idle_need: assert property (@(posedge clk) disable iff (!arst_n)
		(pcnt_q == 2'd0) |-> (need_q == 3'd0))
		else $error("sequence length set with nothing held");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && last_s1) |=> (pcnt_q == 2'd0))
		else $error("sequence held across end of string");

	a_hold_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && n_res == 3'd0) |=> (pcnt_q != 2'd0) && ($past(pcnt_q) != 2'd3))
		else $error("byte swallowed without being held");
`endif

endmodule

// ===== bench/utf8_sanitizer_stream_top_tb.sv =====
module utf8_sanitizer_stream_top_tb;

	localparam int RANDOM_ITEMS   = 245;
	localparam int CALM_ITEMS     = 40;
	localparam int HOLD_CYCLES    = 48;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 400;

	// One row of the directed table; exp is only used when typed is set
	typedef struct packed {
		u8s_pkg::raw_t item;
		bit            typed;
		u8s_pkg::res_t exp;
	} stim_row_t;

	logic           clk;
	logic           arst_n;
	logic           raw_valid;
	logic           raw_stall;
	u8s_pkg::raw_t  raw_item;
	logic           clean_valid;
	logic           clean_stall;
	u8s_pkg::res_t  clean_item;

	// Sanitiser state as the bench sees it
	logic [7:0] held_bytes [3];
	logic [1:0] held_count;
	logic [2:0] want_len;

	u8s_pkg::res_t step_results_q [$];
	u8s_pkg::res_t clean_expected_q [$];
	stim_row_t     stim_table [$];
	u8s_pkg::raw_t random_plan_q [$];

	int mismatches;
	bit hold_req;
	bit hold_taken;
	bit calm;

	utf8_sanitizer_stream_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.raw_valid   (raw_valid),
		.raw_stall   (raw_stall),
		.raw_item    (raw_item),
		.clean_valid (clean_valid),
		.clean_stall (clean_stall),
		.clean_item  (clean_item)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// 1 for ASCII, 2..4 for a lead, 0 for a continuation or a byte that is never valid
	function automatic logic [2:0] seq_class(input logic [7:0] c);
		casez (c)
			8'b0???????: seq_class = 3'd1;
			8'b110?????: seq_class = 3'd2;
			8'b1110????: seq_class = 3'd3;
			8'b11110???: seq_class = 3'd4;
			default:     seq_class = 3'd0;
		endcase
	endfunction

	function automatic void put_clean(input logic [7:0] b);
		u8s_pkg::res_t r;
		r.out_byte    = b;
		r.run_last    = 1'b0;
		r.string_last = 1'b0;
		step_results_q.insert(step_results_q.size(), r);
	endfunction

	// Every held byte goes out as a replacement
	function automatic void flush_held();
		int k;
		for (k = 0; k < int'(held_count); k++)
			put_clean(u8s_pkg::SUB_CHAR);
		held_count = 2'd0;
		want_len   = 3'd0;
	endfunction

	// Works out the transfers one accepted byte releases, into step_results_q
	function automatic void sanitise_byte(input u8s_pkg::raw_t item);
		logic [7:0]    c;
		logic [2:0]    len;
		bit            fresh;
		int            k;
		int            tail;
		u8s_pkg::res_t r;
		c     = item.in_byte;
		fresh = 1'b1;
		step_results_q.delete();
		if (held_count != 2'd0) begin
			if (c[7:6] == 2'b10) begin
				fresh = 1'b0;
				if (int'(held_count) + 1 == int'(want_len)) begin
					for (k = 0; k < int'(held_count); k++)
						put_clean(held_bytes[k]);
					put_clean(c);
					held_count = 2'd0;
					want_len   = 3'd0;
				end else if (item.is_last || held_count == 2'd3) begin
					flush_held();
					put_clean(u8s_pkg::SUB_CHAR);
				end else begin
					held_bytes[held_count] = c;
					held_count = held_count + 2'd1;
				end
			end else begin
				flush_held();
			end
		end
		if (fresh) begin
			len = seq_class(c);
			if (len == 3'd1)
				put_clean(c);
			else if (len == 3'd0 || item.is_last)
				put_clean(u8s_pkg::SUB_CHAR);
			else begin
				held_bytes[0] = c;
				held_count    = 2'd1;
				want_len      = len;
			end
		end
		// end of string leaves nothing held
		if (item.is_last) begin
			held_count = 2'd0;
			want_len   = 3'd0;
		end
		if (step_results_q.size() > 0) begin
			tail          = step_results_q.size() - 1;
			r             = step_results_q[tail];
			r.run_last    = 1'b1;
			r.string_last = item.is_last;
			step_results_q[tail] = r;
		end
	endfunction

	// Appends one row to the directed table
	function automatic void add_row(input logic [7:0] b, input bit last, input bit typed,
			input logic [7:0] ob, input bit rl, input bit sl);
		stim_row_t r;
		r.item.in_byte     = b;
		r.item.is_last     = last;
		r.typed            = typed;
		r.exp.out_byte     = ob;
		r.exp.run_last     = rl;
		r.exp.string_last  = sl;
		stim_table.insert(stim_table.size(), r);
	endfunction

	function automatic logic [7:0] lead_for(input int len);
		case (len)
			2:       lead_for = {3'b110, 5'($urandom)};
			3:       lead_for = {4'b1110, 4'($urandom)};
			default: lead_for = {5'b11110, 3'($urandom)};
		endcase
	endfunction

	function automatic void plan_byte(input logic [7:0] b);
		u8s_pkg::raw_t r;
		r.in_byte = b;
		r.is_last = 1'b0;
		random_plan_q.insert(random_plan_q.size(), r);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] clean transfer: %s got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Offer one byte, with an occasional gap in front, and predict once it is taken
	task automatic offer_byte(input u8s_pkg::raw_t item, input bit typed,
			input u8s_pkg::res_t typed_res);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			repeat (gap) begin
				@(negedge clk);
				raw_valid <= 1'b0;
			end
		end
		@(negedge clk);
		raw_valid <= 1'b1;
		raw_item  <= item;
		@(posedge clk);
		while (raw_stall)
			@(posedge clk);
		sanitise_byte(item);
		if (typed)
			clean_expected_q.insert(clean_expected_q.size(), typed_res);
		else
			foreach (step_results_q[k])
				clean_expected_q.insert(clean_expected_q.size(), step_results_q[k]);
	endtask

	// Result checker
	always @(posedge clk) begin
		u8s_pkg::res_t want;
		if (arst_n && clean_valid && !clean_stall) begin
			if (clean_expected_q.size() == 0)
				report_mismatch("unexpected out_byte", clean_item.out_byte, 0);
			else begin
				want = clean_expected_q.pop_front();
				if (clean_item.out_byte !== want.out_byte)
					report_mismatch("out_byte", clean_item.out_byte, want.out_byte);
				if (clean_item.run_last !== want.run_last)
					report_mismatch("run_last", clean_item.run_last, want.run_last);
				if (clean_item.string_last !== want.string_last)
					report_mismatch("string_last", clean_item.string_last, want.string_last);
			end
		end
	end

	// Receiver stall: short random bursts, one long hold on request
	initial begin : receiver_stall
		int burst;
		clean_stall = 1'b0;
		hold_taken  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				clean_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				clean_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 4);
				clean_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				clean_stall <= 1'b0;
			end else begin
				clean_stall <= 1'b0;
			end
		end
	end

	// Ends the run when no transfer happens on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((raw_valid && !raw_stall) || (clean_valid && !clean_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("** utf8_sanitizer_stream_top: FAILED **");
		$finish;
	end

	initial begin : stimulus
		u8s_pkg::raw_t b;
		int   i;
		int   s;
		int   n_seq;
		int   kind;
		int   len;
		int   conts;
		int   tail;
		int   hold_at;
		int   pause_at;
		raw_valid  = 1'b0;
		raw_item   = '0;
		arst_n     = 1'b0;
		hold_req   = 1'b0;
		calm       = 1'b0;
		mismatches = 0;
		held_count = 2'd0;
		want_len   = 3'd0;

		// Directed table: extremes, strays, every sequence length, broken sequences
		add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0);
		add_row(8'h7F, 1'b1, 1'b1, 8'h7F, 1'b1, 1'b1);
		add_row(8'h80, 1'b0, 1'b1, u8s_pkg::SUB_CHAR, 1'b1, 1'b0);
		add_row(8'hFF, 1'b0, 1'b1, u8s_pkg::SUB_CHAR, 1'b1, 1'b0);
		add_row(8'hF8, 1'b0, 1'b1, u8s_pkg::SUB_CHAR, 1'b1, 1'b0);
		// lead at end of string
		add_row(8'hC2, 1'b1, 1'b1, u8s_pkg::SUB_CHAR, 1'b1, 1'b1);
		// a good pair, a good three-byte sequence, then a good four-byte sequence
		add_row(8'hC3, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'hA9, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'hE2, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'h82, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'hAC, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'hF0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'h9F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'h98, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'h80, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		// overlong lead passes unchecked
		add_row(8'hC0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'h80, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		// four-byte run broken by ASCII: four transfers from one byte
		add_row(8'hF7, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'hBF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'hBF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		// continuation at end of string that does not complete
		add_row(8'hE2, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'h82, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		// held lead broken by an invalid byte at end of string
		add_row(8'hF5, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_table[r])
			offer_byte(stim_table[r].item, stim_table[r].typed, stim_table[r].exp);

		// Random strings: mostly well-formed sequences, some broken ones and noise
		while (random_plan_q.size() < RANDOM_ITEMS) begin
			n_seq = $urandom_range(1, 8);
			for (s = 0; s < n_seq; s++) begin
				kind = $urandom_range(0, 9);
				len  = $urandom_range(2, 4);
				if (kind <= 2)
					plan_byte({1'b0, 7'($urandom)});
				else if (kind <= 6) begin
					plan_byte(lead_for(len));
					conts = (kind == 6) ? $urandom_range(0, len - 2) : len - 1;
					repeat (conts) plan_byte({2'b10, 6'($urandom)});
				end else if (kind == 7)
					plan_byte({2'b10, 6'($urandom)});
				else if (kind == 8)
					plan_byte(8'($urandom));
				else
					plan_byte({5'b11111, 3'($urandom)});
			end
			tail          = random_plan_q.size() - 1;
			b             = random_plan_q[tail];
			b.is_last     = 1'b1;
			random_plan_q[tail] = b;
		end

		hold_at  = $urandom_range(30, 80);
		pause_at = $urandom_range(120, 180);
		for (i = 0; i < random_plan_q.size(); i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			// sender stands back until every expected transfer has come
			if (i == pause_at) begin
				@(negedge clk);
				raw_valid <= 1'b0;
				while (clean_expected_q.size() != 0)
					@(negedge clk);
			end
			if (i == random_plan_q.size() - CALM_ITEMS)
				calm = 1'b1;
			offer_byte(random_plan_q[i], 1'b0, '0);
		end

		@(negedge clk);
		raw_valid <= 1'b0;
		while (clean_expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("** utf8_sanitizer_stream_top: PASSED **");
		else
			$display("** utf8_sanitizer_stream_top: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/u8s_pkg.sv
hdl/utf8_sanitizer_stream_top.sv
bench/utf8_sanitizer_stream_top_tb.sv
